FILE: rtl/mcop_pkg.sv
package mcop_pkg;

	localparam int unsigned COORD_W = 12;
	localparam int unsigned CENTRE_W = 11;
	localparam int unsigned RADIUS_IN_W = 10;

	localparam logic OP_START = 1'b0;
	localparam logic OP_STEP  = 1'b1;

	// Octant point slots in emission order: white points first, then black.
	localparam logic [2:0] SLOT_PXPY = 3'd0;
	localparam logic [2:0] SLOT_NXNY = 3'd1;
	localparam logic [2:0] SLOT_NYPX = 3'd2;
	localparam logic [2:0] SLOT_PYNX = 3'd3;
	localparam logic [2:0] SLOT_NXPY = 3'd4;
	localparam logic [2:0] SLOT_PXNY = 3'd5;
	localparam logic [2:0] SLOT_PYPX = 3'd6;
	localparam logic [2:0] SLOT_NYNX = 3'd7;

	typedef struct packed {
		logic [COORD_W-1:0]         arc_x;
		logic [COORD_W-1:0]         arc_y;
		logic signed [CENTRE_W-1:0] centre_x;
		logic signed [CENTRE_W-1:0] centre_y;
		logic                       done;
	} job_t;

endpackage

FILE: rtl/mcop_req_if.sv
interface mcop_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic [9:0]         radius;
	logic signed [10:0] centre_x;
	logic signed [10:0] centre_y;

	modport source(output valid, output op, output radius, output centre_x,
		output centre_y, input ready);
	modport sink(input valid, input op, input radius, input centre_x,
		input centre_y, output ready);
endinterface

FILE: rtl/mcop_pt_if.sv
interface mcop_pt_if;
	logic               valid;
	logic               ready;
	logic signed [11:0] point_x;
	logic signed [11:0] point_y;
	logic               colour;
	logic               last_of_step;
	logic               circle_done;

	modport source(output valid, output point_x, output point_y, output colour,
		output last_of_step, output circle_done, input ready);
	modport sink(input valid, input point_x, input point_y, input colour,
		input last_of_step, input circle_done, output ready);
endinterface

FILE: rtl/mcop_front.sv
module mcop_front #(
	parameter int RADIUS_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	mcop_req_if.sink      req,
	input  logic          queue_full,
	output logic          push,
	output mcop_pkg::job_t push_job
);
	import mcop_pkg::*;

	localparam int DW = RADIUS_BITS + 3;

	logic [RADIUS_BITS-1:0]  arc_x_q;
	logic [RADIUS_BITS-1:0]  arc_y_q;
	logic signed [DW-1:0]    decision_q;
	logic signed [CENTRE_W-1:0] centre_x_q;
	logic signed [CENTRE_W-1:0] centre_y_q;
	logic                    active_q;

	logic                    accept;
	logic [RADIUS_BITS+RADIUS_IN_W-1:0] radius_ext;
	logic [RADIUS_BITS-1:0]  start_r;
	logic [RADIUS_BITS-1:0]  next_x;
	logic [RADIUS_BITS-1:0]  next_y;
	logic signed [DW-1:0]    next_d;
	logic                    next_done;
	logic [RADIUS_BITS+COORD_W-1:0] x_ext;
	logic [RADIUS_BITS+COORD_W-1:0] y_ext;

	assign req.ready = !queue_full;
	assign accept = req.valid && req.ready;

	assign radius_ext = {{RADIUS_BITS{1'b0}}, req.radius};
	assign start_r = radius_ext[RADIUS_BITS-1:0];

	always_comb begin
		next_y = arc_y_q + RADIUS_BITS'(1);
		next_x = arc_x_q;
		if (decision_q < 0) begin
			next_d = decision_q + $signed({2'b00, next_y, 1'b1});
		end else begin
			next_x = arc_x_q - RADIUS_BITS'(1);
			next_d = decision_q + $signed({2'b00, next_y, 1'b1})
				- $signed({2'b00, next_x, 1'b0});
		end
		next_done = !(next_x > next_y);
	end

	assign x_ext = {{COORD_W{1'b0}}, next_x};
	assign y_ext = {{COORD_W{1'b0}}, next_y};

	assign push = accept && (req.op == OP_STEP) && active_q && (arc_x_q > arc_y_q);
	assign push_job = '{arc_x: x_ext[COORD_W-1:0], arc_y: y_ext[COORD_W-1:0],
		centre_x: centre_x_q, centre_y: centre_y_q, done: next_done};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arc_x_q    <= '0;
			arc_y_q    <= '0;
			decision_q <= '0;
			centre_x_q <= '0;
			centre_y_q <= '0;
			active_q   <= 1'b0;
		end else if (accept) begin
			if (req.op == OP_START) begin
				arc_x_q    <= start_r;
				arc_y_q    <= '0;
				decision_q <= DW'(1) - $signed({3'b000, start_r});
				centre_x_q <= req.centre_x;
				centre_y_q <= req.centre_y;
				active_q   <= (start_r != '0);
			end else if (push) begin
				arc_x_q    <= next_x;
				arc_y_q    <= next_y;
				decision_q <= next_d;
				if (next_done) begin
					active_q <= 1'b0;
				end
			end
		end
	end

endmodule

FILE: rtl/mcop_queue.sv
module mcop_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mcop_pkg::job_t push_job,
	output logic           full,
	output logic           empty,
	input  logic           pop,
	output mcop_pkg::job_t head
);
	import mcop_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign empty = (count_q == 2'd0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/mcop_back.sv
module mcop_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           empty,
	input  mcop_pkg::job_t head,
	output logic           pop,
	mcop_pt_if.source      pt
);
	import mcop_pkg::*;

	logic [2:0]         slot_q;
	logic               valid_q;
	logic [COORD_W-1:0] point_x_q;
	logic [COORD_W-1:0] point_y_q;
	logic               colour_q;
	logic               last_q;
	logic               done_q;

	logic               load;
	logic               advance;
	logic [COORD_W-1:0] cx;
	logic [COORD_W-1:0] cy;
	logic [COORD_W-1:0] px;
	logic [COORD_W-1:0] py;

	assign load    = !valid_q || pt.ready;
	assign advance = load && !empty;
	assign pop     = advance && (slot_q == SLOT_NYNX);

	assign cx = {head.centre_x[CENTRE_W-1], head.centre_x};
	assign cy = {head.centre_y[CENTRE_W-1], head.centre_y};

	always_comb begin
		unique case (slot_q)
			SLOT_PXPY: begin px = cx + head.arc_x; py = cy + head.arc_y; end
			SLOT_NXNY: begin px = cx - head.arc_x; py = cy - head.arc_y; end
			SLOT_NYPX: begin px = cx - head.arc_y; py = cy + head.arc_x; end
			SLOT_PYNX: begin px = cx + head.arc_y; py = cy - head.arc_x; end
			SLOT_NXPY: begin px = cx - head.arc_x; py = cy + head.arc_y; end
			SLOT_PXNY: begin px = cx + head.arc_x; py = cy - head.arc_y; end
			SLOT_PYPX: begin px = cx + head.arc_y; py = cy + head.arc_x; end
			SLOT_NYNX: begin px = cx - head.arc_y; py = cy - head.arc_x; end
			default:   begin px = cx; py = cy; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q  <= SLOT_PXPY;
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= !empty;
			if (!empty) begin
				slot_q <= slot_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			point_x_q <= px;
			point_y_q <= py;
			colour_q  <= !slot_q[2];
			last_q    <= (slot_q == SLOT_NYNX);
			done_q    <= head.done;
		end
	end

	assign pt.valid        = valid_q;
	assign pt.point_x      = $signed(point_x_q);
	assign pt.point_y      = $signed(point_y_q);
	assign pt.colour       = colour_q;
	assign pt.last_of_step = last_q;
	assign pt.circle_done  = done_q;

endmodule

FILE: rtl/midpoint_circle_octant_plotter.sv
// An accepted step request is written to the queue, and its first point is then loaded into
// the output register; the eight points of a step follow at one per cycle while pt.ready
// holds, so a steady stream of steps is limited by the single point output port.
// Start requests and idle steps are accepted without giving points. A two-entry queue
// between the arc update and the point emitter lets requests enter while points drain.
// Reset clears the arc state and leaves no circle in progress.
module midpoint_circle_octant_plotter #(
	parameter int RADIUS_BITS = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	mcop_req_if.sink  req,
	mcop_pt_if.source pt
);
	import mcop_pkg::*;

	logic push;
	job_t push_job;
	logic full;
	logic empty;
	logic pop;
	job_t head;

	mcop_front #(
		.RADIUS_BITS(RADIUS_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.queue_full (full),
		.push       (push),
		.push_job   (push_job)
	);

	mcop_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.full     (full),
		.empty    (empty),
		.pop      (pop),
		.head     (head)
	);

	mcop_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.pt     (pt)
	);

endmodule
